FILE: rtl/led_dac_pkg.sv
`default_nettype none

package led_dac_pkg;

  // Command codes
  localparam logic [1:0] CMD_SET_CURRENT = 2'd0;
  localparam logic [1:0] CMD_SET_LEVEL   = 2'd1;
  localparam logic [1:0] CMD_STEP_LEVEL  = 2'd2;
  localparam logic [1:0] CMD_READ        = 2'd3;

  // Current limits and scaling
  localparam logic [14:0] CUR_MAX    = 15'd25000;
  localparam logic [15:0] MA_LIMIT   = 16'd30;
  localparam logic [9:0]  MA_SCALE   = 10'd1000;
  localparam logic [6:0]  SEARCH_END = 7'd127;

  // DAC conversion: code = ((current + 120) * 4481) >> 15
  localparam logic [6:0]  DAC_OFFSET = 7'd120;
  localparam logic [12:0] DAC_MUL    = 13'd4481;
  localparam int          DAC_SHIFT  = 15;
  localparam int          PROD_W     = 28;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       current_request;
    logic [7:0]        level_request;
    logic signed [7:0] level_step;
  } led_dac_in_t;

  typedef struct packed {
    logic        dac_write;
    logic [11:0] dac_code;
    logic [14:0] current_now;
    logic [7:0]  level_now;
  } led_dac_out_t;

  // Drive current curve over the level range: rises to a peak, then falls back
  localparam logic [14:0] LED_CURVE [0:255] = '{
    15'd740, 15'd800, 15'd860, 15'd920, 15'd990, 15'd1050, 15'd1120, 15'd1200,
    15'd1270, 15'd1340, 15'd1420, 15'd1500, 15'd1580, 15'd1670, 15'd1760, 15'd1840,
    15'd1940, 15'd2030, 15'd2120, 15'd2220, 15'd2320, 15'd2420, 15'd2530, 15'd2630,
    15'd2740, 15'd2850, 15'd2970, 15'd3080, 15'd3200, 15'd3320, 15'd3440, 15'd3570,
    15'd3690, 15'd3820, 15'd3950, 15'd4080, 15'd4220, 15'd4360, 15'd4490, 15'd4640,
    15'd4780, 15'd4930, 15'd5070, 15'd5220, 15'd5380, 15'd5530, 15'd5690, 15'd5850,
    15'd6010, 15'd6170, 15'd6340, 15'd6510, 15'd6680, 15'd6850, 15'd7020, 15'd7200,
    15'd7380, 15'd7560, 15'd7740, 15'd7930, 15'd8120, 15'd8310, 15'd8500, 15'd8690,
    15'd8890, 15'd9090, 15'd9290, 15'd9490, 15'd9700, 15'd9900, 15'd10110, 15'd10330,
    15'd10540, 15'd10760, 15'd10970, 15'd11190, 15'd11420, 15'd11640, 15'd11870,
    15'd12100, 15'd12330, 15'd12560, 15'd12800, 15'd13040, 15'd13280, 15'd13520,
    15'd13770, 15'd14010, 15'd14260, 15'd14510, 15'd14770, 15'd15020, 15'd15280,
    15'd15540, 15'd15800, 15'd16070, 15'd16330, 15'd16600, 15'd16870, 15'd17150,
    15'd17420, 15'd17700, 15'd17980, 15'd18260, 15'd18550, 15'd18830, 15'd19120,
    15'd19410, 15'd19700, 15'd20000, 15'd20300, 15'd20600, 15'd20900, 15'd21200,
    15'd21510, 15'd21820, 15'd22130, 15'd22440, 15'd22760, 15'd23070, 15'd23390,
    15'd23710, 15'd24040, 15'd24360, 15'd24690, 15'd25020, 15'd25350, 15'd25690,
    15'd25690, 15'd25350, 15'd25020, 15'd24690, 15'd24360, 15'd24040, 15'd23710,
    15'd23390, 15'd23070, 15'd22760, 15'd22440, 15'd22130, 15'd21820, 15'd21510,
    15'd21200, 15'd20900, 15'd20600, 15'd20300, 15'd20000, 15'd19700, 15'd19410,
    15'd19120, 15'd18830, 15'd18550, 15'd18260, 15'd17980, 15'd17700, 15'd17420,
    15'd17150, 15'd16870, 15'd16600, 15'd16330, 15'd16070, 15'd15800, 15'd15540,
    15'd15280, 15'd15020, 15'd14770, 15'd14510, 15'd14260, 15'd14010, 15'd13770,
    15'd13520, 15'd13280, 15'd13040, 15'd12800, 15'd12560, 15'd12330, 15'd12100,
    15'd11870, 15'd11640, 15'd11420, 15'd11190, 15'd10970, 15'd10760, 15'd10540,
    15'd10330, 15'd10110, 15'd9900, 15'd9700, 15'd9490, 15'd9290, 15'd9090, 15'd8890,
    15'd8690, 15'd8500, 15'd8310, 15'd8120, 15'd7930, 15'd7740, 15'd7560, 15'd7380,
    15'd7200, 15'd7020, 15'd6850, 15'd6680, 15'd6510, 15'd6340, 15'd6170, 15'd6010,
    15'd5850, 15'd5690, 15'd5530, 15'd5380, 15'd5220, 15'd5070, 15'd4930, 15'd4780,
    15'd4640, 15'd4490, 15'd4360, 15'd4220, 15'd4080, 15'd3950, 15'd3820, 15'd3690,
    15'd3570, 15'd3440, 15'd3320, 15'd3200, 15'd3080, 15'd2970, 15'd2850, 15'd2740,
    15'd2630, 15'd2530, 15'd2420, 15'd2320, 15'd2220, 15'd2120, 15'd2030, 15'd1940,
    15'd1840, 15'd1760, 15'd1670, 15'd1580, 15'd1500, 15'd1420, 15'd1340, 15'd1270,
    15'd1200, 15'd1120, 15'd1050, 15'd990, 15'd920, 15'd860, 15'd800, 15'd740
  };

  // Limit a current value to the maximum drive current
  function automatic logic [14:0] cur_clamp(input logic [15:0] c);
    logic [14:0] res;
    if (c > {1'b0, CUR_MAX}) begin
      res = CUR_MAX;
    end else begin
      res = c[14:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/led_brightness_dac_control.sv
`default_nettype none

// LED drive controller. A command is taken when start is high and busy is
// low; busy then stays high until the result beat has gone out on out_valid,
// which is high for exactly one cycle and cannot be held off by the receiver.
// Read goes from acceptance through S_PREP to the result beat in S_EMIT;
// set level and step level pass through S_PREP and S_MUL. Set current walks
// the curve table from level 0 upward in S_SEARCH with one comparator, one
// entry per cycle, until it settles on a level n in 0..127. The DAC code
// product is formed in its own state, S_MUL, after the current is settled.
// busy drops in the cycle after the result beat, so the next command is
// taken in the cycle after that beat at the earliest.
module led_brightness_dac_control
  import led_dac_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire led_dac_in_t  in_data,
  output logic              out_valid,
  output led_dac_out_t      out_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_MUL    = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  led_dac_in_t        in_r;
  logic [7:0]         level_r, level_nxt;
  logic [14:0]        cur_r, cur_nxt;
  logic               wr_r, wr_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;

  logic [7:0]         step_level;
  logic [15:0]        ma_scaled;
  logic [15:0]        req_scaled;
  logic [14:0]        search_entry;
  logic               search_more;
  logic [15:0]        cur_offset;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  // Level after a signed step, wrapping around
  assign step_level = level_r + $unsigned(in_r.level_step);

  // Milliamp requests scale to micro units
  assign ma_scaled  = {11'd0, in_r.current_request[4:0]} * {6'd0, MA_SCALE};
  assign req_scaled = (in_r.current_request < MA_LIMIT) ? ma_scaled : in_r.current_request;

  // Search compare: keep walking while the table entry is below the target and level 127 is not reached
  assign search_entry = LED_CURVE[level_r];
  assign search_more  = (level_r[6:0] != SEARCH_END) && (search_entry < cur_r);

  assign cur_offset = {1'b0, cur_r} + {9'd0, DAC_OFFSET};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    cur_nxt   = cur_r;
    wr_nxt    = wr_r;
    prod_nxt  = prod_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        wr_nxt = 1'b1;
        case (in_r.cmd)
          CMD_SET_CURRENT: begin
            cur_nxt   = cur_clamp(req_scaled);
            level_nxt = 8'd0;
            state_nxt = S_SEARCH;
          end
          CMD_SET_LEVEL: begin
            level_nxt = in_r.level_request;
            cur_nxt   = cur_clamp({1'b0, LED_CURVE[in_r.level_request]});
            state_nxt = S_MUL;
          end
          CMD_STEP_LEVEL: begin
            level_nxt = step_level;
            cur_nxt   = cur_clamp({1'b0, LED_CURVE[step_level]});
            state_nxt = S_MUL;
          end
          CMD_READ: begin
            wr_nxt    = 1'b0;
            state_nxt = S_EMIT;
          end
          default: begin
            wr_nxt    = 1'b0;
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_SEARCH: begin
        // advance one entry per cycle until the curve reaches the current or level 127
        if (search_more) begin
          level_nxt = level_r + 8'd1;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = {12'd0, cur_offset} * {15'd0, DAC_MUL};
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      level_r <= 8'd0;
      cur_r   <= 15'd0;
      wr_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      cur_r   <= cur_nxt;
      wr_r    <= wr_nxt;
    end
  end

  // Hold the command beat and the product
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    prod_r <= prod_nxt;
  end

  // Result beat
  always_comb begin
    out_data.dac_write   = wr_r;
    out_data.dac_code    = wr_r ? prod_r[DAC_SHIFT +: 12] : 12'd0;
    out_data.current_now = cur_r;
    out_data.level_now   = level_r;
  end

endmodule

`default_nettype wire
